[hdl/cftc_pkg.sv]
// Shared types and constants for the contiguous file table compactor.
package cftc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 32;
  localparam int SIZE_W      = 16;
  localparam int OUT_ID_W    = 7;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_CMP = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  file_key;
    logic [SIZE_W-1:0] file_size;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [OUT_ID_W-1:0] file_id;
    logic [SIZE_W-1:0]   free_left;
    logic [OUT_ID_W-1:0] entries_used;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add;
    logic walk;
    logic commit;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic walk_cmd;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/cftc_stream_if.sv]
// Valid/ready stream interface used for the item and result channels.
interface cftc_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/cftc_ctrl.sv]
// Controller state machine sequencing add, delete and compact operations.
module cftc_ctrl
  import cftc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_COMMIT,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.walk_cmd) begin
          state_nxt = S_WALK;
        end else begin
          cmd.add   = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/cftc_datapath.sv]
// Datapath: entry table memory, counters, free space and result register.
module cftc_datapath
  import cftc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  in_item_t          in_data,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [CW-1:0]     id;
  } entry_t;

  entry_t mem [ENTRIES];

  // Control state.
  logic [CW-1:0]     cnt_r;
  logic [SIZE_W-1:0] free_r;
  logic [CW-1:0]     rd_r;
  logic [CW-1:0]     wr_r;
  logic              pend_r;
  logic              hit_r;
  logic              out_valid_r;

  // Payload registers.
  cmd_t              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;
  status_t           st_r;
  logic [CW-1:0]     id_r;
  logic [AW-1:0]     pidx_r;
  entry_t            rdata_r;
  out_item_t         out_data_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              full;
  logic              nospace;
  logic              match;
  logic              live;
  logic              out_free;
  logic [SIZE_W:0]   credit_sum;
  logic [SIZE_W-1:0] credited;
  logic [CW-1:0]     id_new;
  logic [CW+OUT_ID_W-1:0] id_ext;
  logic [CW+OUT_ID_W-1:0] cnt_ext;

  assign full       = (cnt_r == CW'(ENTRIES));
  assign nospace    = (size_r > free_r);
  assign id_new     = cnt_r + 1'b1;
  assign live       = (rdata_r.id != '0);
  assign match      = live && (rdata_r.key == key_r);
  assign credit_sum = {1'b0, free_r} + {1'b0, rdata_r.size};
  assign credited   = credit_sum[SIZE_W] ? '1 : credit_sum[SIZE_W-1:0];
  assign out_free   = !out_valid_r || out_ready;
  assign id_ext     = {{OUT_ID_W{1'b0}}, id_r};
  assign cnt_ext    = {{OUT_ID_W{1'b0}}, cnt_r};

  assign stat.walk_cmd  = (cmd_r == CMD_DEL) || (cmd_r == CMD_CMP);
  assign stat.walk_done = (rd_r == cnt_r) && !pend_r;
  assign stat.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Table write port: add appends, delete clears the id, compact moves down.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = '{key: key_r, size: size_r, id: id_new};
    if (cmd.add && (cmd_r == CMD_ADD) && !full && !nospace) begin
      mem_we = 1'b1;
    end else if (cmd.walk && pend_r) begin
      if (cmd_r == CMD_DEL) begin
        mem_we    = match;
        mem_waddr = pidx_r;
        mem_wdata = '{key: rdata_r.key, size: rdata_r.size, id: '0};
      end else begin
        mem_we    = live;
        mem_waddr = wr_r[AW-1:0];
        mem_wdata = rdata_r;
      end
    end
  end

  // The walk writes only behind its read pointer, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      free_r <= '0;
      rd_r   <= '0;
      wr_r   <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (cfg_we) begin
      cnt_r  <= '0;
      free_r <= cfg_wdata;
    end else begin
      if (cmd.load) begin
        cmd_r  <= in_data.cmd;
        key_r  <= in_data.file_key;
        size_r <= in_data.file_size;
        st_r   <= ST_OK;
        id_r   <= '0;
        rd_r   <= '0;
        wr_r   <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end
      if (cmd.add && (cmd_r == CMD_ADD)) begin
        if (full) begin
          st_r <= ST_FULL;
        end else if (nospace) begin
          st_r <= ST_NOSPACE;
        end else begin
          id_r   <= id_new;
          cnt_r  <= id_new;
          free_r <= free_r - size_r;
        end
      end
      if (cmd.walk) begin
        if (rd_r != cnt_r) begin
          pidx_r <= rd_r[AW-1:0];
          rd_r   <= rd_r + 1'b1;
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r) begin
          if (cmd_r == CMD_DEL) begin
            if (match) begin
              free_r <= credited;
              hit_r  <= 1'b1;
            end
          end else if (live) begin
            wr_r <= wr_r + 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        if (cmd_r == CMD_CMP) begin
          cnt_r <= wr_r;
        end else if (!hit_r) begin
          st_r <= ST_NOTFOUND;
        end
      end
    end
  end

  // Result register: holds one result so the next item can be taken meanwhile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status       <= st_r;
      out_data_r.file_id      <= id_ext[OUT_ID_W-1:0];
      out_data_r.free_left    <= free_r;
      out_data_r.entries_used <= cnt_ext[OUT_ID_W-1:0];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("entry count beyond table depth");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> wr_r <= rd_r)
    else $error("compaction write pointer ahead of read pointer");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_walk_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> !cmd.add && !cmd.load)
    else $error("add or load issued during a table walk");

endmodule

[hdl/contiguous_file_table_compactor.sv]
// Top level of the contiguous file table compactor.
//
//   channel | direction | handshake        | payload
//   in_ch   | in        | valid / ready    | cmd, file_key, file_size
//   out_ch  | out       | valid / ready    | status, file_id, free_left, entries_used
//   cfg_*   | in        | cfg_we, no wait  | cfg_wdata (memory size)
//
// An add passes through the execute and result states after the item is accepted; a
// delete or a compact first walks every entry of the single-read table memory and
// commits, so its run grows with the entry count.
// One item is in work at a time; the next is accepted once the result is in the
// output register, even while that result waits to be taken.
// Reset (synchronous, rst_n low) empties the table and sets the free space to 0.
// A configuration write empties the table and loads the free space.
module contiguous_file_table_compactor
  import cftc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cftc_stream_if.sink       in_ch,
  cftc_stream_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  in_item_t  in_data;
  out_item_t out_data;

  assign in_data     = in_ch.data;
  assign out_ch.data = out_data;

  cftc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cftc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the contiguous file table compactor.
`timescale 1ns / 100ps

module tb;
  import cftc_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_STALL  = 600;
  localparam int SETTLE      = ENTRIES + 10;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  cftc_stream_if #(.item_t(in_item_t))  in_if ();
  cftc_stream_if #(.item_t(out_item_t)) out_if ();

  contiguous_file_table_compactor #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Mirror of the file table.
  logic [KEY_W-1:0]  tbl_key  [ENTRIES];
  logic [SIZE_W-1:0] tbl_size [ENTRIES];
  int                tbl_id   [ENTRIES];
  int                tbl_count;
  int                tbl_free;
  int                mem_model;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  logic [31:0] key_pool[$];

  int       err_count;
  int       result_count;
  int       idle_cycles;
  logic     in_acc;
  logic     all_drained;
  logic     flow_idle;
  logic     send_hold;
  logic     no_idle;
  logic     rx_stall_req;
  logic     rx_stall_done;
  int       rx_stall_left;
  int       rx_seg_left;
  int       rx_tick;
  rx_mode_t rx_mode;
  int       gap_left;
  int       burst_left;

  always #5 clk = ~clk;

  function automatic void table_clear();
    tbl_count = 0;
    tbl_free  = mem_model;
  endfunction

  function automatic out_item_t table_apply(in_item_t it);
    out_item_t r;
    logic      hit;
    int        wr;
    r.status  = ST_OK;
    r.file_id = '0;
    hit       = 1'b0;
    wr        = 0;
    case (it.cmd)
      CMD_ADD: begin
        // The full-table check takes precedence over the space check.
        if (tbl_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else if (int'(it.file_size) > tbl_free) begin
          r.status = ST_NOSPACE;
        end else begin
          tbl_key[tbl_count]  = it.file_key;
          tbl_size[tbl_count] = it.file_size;
          tbl_id[tbl_count]   = tbl_count + 1;
          r.file_id           = OUT_ID_W'(tbl_count + 1);
          tbl_free            = tbl_free - int'(it.file_size);
          tbl_count++;
        end
      end
      CMD_DEL: begin
        // Only live entries match, so a deleted entry is never credited twice.
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] != 0 && tbl_key[i] == it.file_key) begin
            tbl_free = tbl_free + int'(tbl_size[i]);
            if (tbl_free > 65535) tbl_free = 65535;
            tbl_id[i] = 0;
            hit       = 1'b1;
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      CMD_CMP: begin
        for (int rd = 0; rd < tbl_count; rd++) begin
          if (tbl_id[rd] != 0) begin
            tbl_key[wr]  = tbl_key[rd];
            tbl_size[wr] = tbl_size[rd];
            tbl_id[wr]   = tbl_id[rd];
            wr++;
          end
        end
        tbl_count = wr;
      end
      default: ;
    endcase
    r.free_left    = SIZE_W'(tbl_free);
    r.entries_used = OUT_ID_W'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("mismatch at result %0d: %s", result_count, msg);
    err_count++;
  endtask

  // Result checker and predictor; everything here is sampled at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      in_acc      <= 1'b0;
      all_drained <= 1'b0;
      flow_idle   <= 1'b0;
      mem_model   = 0;
      table_clear();
    end else begin
      in_acc <= in_if.valid && in_if.ready;
      if (cfg_we) begin
        mem_model = int'(cfg_wdata);
        table_clear();
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.file_id !== want.file_id)
            report_mismatch($sformatf("file_id %0d, expected %0d", got.file_id, want.file_id));
          if (got.free_left !== want.free_left)
            report_mismatch($sformatf("free_left %0d, expected %0d",
                                      got.free_left, want.free_left));
          if (got.entries_used !== want.entries_used)
            report_mismatch($sformatf("entries_used %0d, expected %0d",
                                      got.entries_used, want.entries_used));
        end
        result_count++;
      end
      if (in_if.valid && in_if.ready) expected_results.push_back(table_apply(in_if.data));
      flow_idle   <= !in_if.valid && expected_results.size() == 0;
      all_drained <= !in_if.valid && expected_results.size() == 0 && pending_items.size() == 0;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    in_item_t nxt;
    logic     nv;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      gap_left    = 0;
      burst_left  = 0;
    end else if (!(in_if.valid && !in_acc)) begin
      nv  = 1'b0;
      nxt = in_if.data;
      if (gap_left > 0 && !no_idle) begin
        gap_left--;
      end else if (pending_items.size() != 0 && !send_hold) begin
        nxt = pending_items.pop_front();
        nv  = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_if.valid <= nv;
      in_if.data  <= nxt;
    end
  end

  // Receiver: changes its stall pattern every segment, plus one long hold-off on request.
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (!rst_n) begin
      nr            = 1'b0;
      rx_stall_done = 1'b0;
      rx_stall_left = 0;
      rx_seg_left   = 0;
      rx_tick       = 0;
      rx_mode       = RX_FREE;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      nr = 1'b0;
    end else if (rx_stall_req && !rx_stall_done) begin
      rx_stall_done = 1'b1;
      rx_stall_left = LONG_STALL;
      nr            = 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_mode     = rx_mode_t'($urandom_range(0, 3));
        rx_seg_left = $urandom_range(10, 150);
        rx_tick     = 0;
      end else begin
        rx_seg_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_FREE:     nr = 1'b1;
        RX_COIN:     nr = 1'($urandom_range(0, 1));
        RX_PERIODIC: nr = (rx_tick % 7) >= 3;
        default:     nr = $urandom_range(0, 7) != 0;
      endcase
      if (no_idle) nr = 1'b1;
    end
    out_if.ready <= nr;
  end

  // A run that makes no progress for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input cmd_t c, input logic [31:0] k, input logic [15:0] s);
    in_item_t it;
    it.cmd       = c;
    it.file_key  = k;
    it.file_size = s;
    pending_items.push_back(it);
  endtask

  task automatic gen_random(input int n, input int w_add, input int w_del, input int w_cmp,
                            input int size_max);
    cmd_t        c;
    logic [31:0] k;
    logic [15:0] s;
    int          r;
    int          pick;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_add) c = CMD_ADD;
      else if (r < w_add + w_del) c = CMD_DEL;
      else if (r < w_add + w_del + w_cmp) c = CMD_CMP;
      else c = CMD_NOP;
      pick = $urandom_range(0, 15);
      if (pick == 0) s = '0;
      else if (pick == 1) s = 16'($urandom);
      else s = 16'($urandom_range(0, size_max));
      // Deletes mostly aim at keys already added; some adds reuse a key on purpose.
      if (key_pool.size() != 0 &&
          ((c == CMD_DEL && $urandom_range(0, 3) != 0) ||
           (c == CMD_ADD && $urandom_range(0, 3) == 0))) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        k = $urandom;
        if (c == CMD_ADD) begin
          key_pool.push_back(k);
          if (key_pool.size() > 24) void'(key_pool.pop_front());
        end
      end
      push_item(c, k, s);
    end
  endtask

  // The first rising edge refreshes the drained flag after new items were queued.
  task automatic wait_drained();
    @(posedge clk);
    do @(negedge clk); while (!all_drained);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mem_size(input logic [SIZE_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    send_hold     = 1'b0;
    no_idle       = 1'b0;
    rx_stall_req  = 1'b0;
    err_count     = 0;
    result_count  = 0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks on a small memory.
    set_mem_size(16'd100);
    push_item(CMD_NOP, $urandom, 16'($urandom));
    push_item(CMD_DEL, 32'h0000_0000, 16'd0);
    push_item(CMD_CMP, 32'h0000_0000, 16'd0);
    push_item(CMD_ADD, 32'h0000_0000, 16'd0);
    push_item(CMD_ADD, 32'hFFFF_FFFF, 16'd100);
    push_item(CMD_ADD, 32'h0000_0001, 16'd1);
    push_item(CMD_DEL, 32'hFFFF_FFFF, 16'd0);
    push_item(CMD_DEL, 32'hFFFF_FFFF, 16'd0);
    push_item(CMD_ADD, 32'h0000_0005, 16'd10);
    push_item(CMD_ADD, 32'h0000_0005, 16'd10);
    push_item(CMD_DEL, 32'h0000_0005, 16'hFFFF);
    push_item(CMD_CMP, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(CMD_ADD, 32'h0000_0007, 16'd20);
    push_item(CMD_ADD, 32'h0000_0008, 16'd30);
    push_item(CMD_DEL, 32'h0000_0007, 16'd0);
    push_item(CMD_CMP, 32'h0000_0000, 16'd0);
    // After the compact the next id repeats one still held in the table.
    push_item(CMD_ADD, 32'h0000_0009, 16'd5);
    push_item(CMD_ADD, $urandom, 16'hFFFF);
    push_item(CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    set_mem_size(16'hFFFF);
    push_item(CMD_ADD, 32'hA5A5_5A5A, 16'hFFFF);
    push_item(CMD_ADD, 32'h0000_0000, 16'd0);
    push_item(CMD_DEL, 32'hA5A5_5A5A, 16'd0);
    push_item(CMD_CMP, 32'h0000_0000, 16'd0);
    wait_drained();

    set_mem_size(16'd1000);
    gen_random(300, 50, 30, 15, 60);
    wait_drained();

    // Add-heavy with small sizes so the table fills; the receiver holds off meanwhile.
    set_mem_size(16'hFFFF);
    gen_random(250, 85, 10, 3, 10);
    rx_stall_req <= 1'b1;
    wait_drained();

    set_mem_size(16'($urandom));
    gen_random(250, 45, 35, 15, $urandom_range(16, 65535));
    do @(posedge clk); while (pending_items.size() > 125);
    send_hold <= 1'b1;
    do @(negedge clk); while (!flow_idle);
    repeat (20) @(negedge clk);
    send_hold <= 1'b0;
    wait_drained();

    set_mem_size(16'd0);
    gen_random(120, 60, 25, 10, 2);
    wait_drained();

    set_mem_size(16'd300);
    no_idle <= 1'b1;
    gen_random(250, 50, 30, 15, 40);
    wait_drained();
    no_idle <= 1'b0;

    repeat (SETTLE) @(negedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
